FILE: rtl/sda_pkg.sv
`timescale 1ns / 1ps
// sda_pkg: shared types, constants and config register codes for the
// SLIC distance assignment core. No dependencies.

package sda_pkg;

	localparam int PIXEL_COUNT_DEF = 65536;
	localparam int LABEL_BITS_DEF  = 12;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int INDEX_W    = 20;
	localparam int DIST_W     = 40;
	localparam int TAG_W      = 4;
	localparam int LBL_W      = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPATIAL_FACTOR = 3'd0,
		CFG_THREE_D        = 3'd1,
		CFG_COLOR_MODE     = 3'd2,
		CFG_IMAGE_WIDTH    = 3'd3,
		CFG_IMAGE_HEIGHT   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] spatial_factor;
		logic        three_d;
		logic        color_mode;
		logic [10:0] image_width;
		logic [10:0] image_height;
	} cfg_t;

	typedef struct packed {
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [9:0]  pixel_z;
		logic [23:0] pixel_color;
		logic [13:0] center_x;
		logic [13:0] center_y;
		logic [13:0] center_z;
		logic [35:0] center_color;
		logic [11:0] cell_label;
		logic [3:0]  pass_tag;
	} item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] pixel_index;
		logic               won;
		logic [LBL_W-1:0]   best_label;
		logic [DIST_W-1:0]  best_distance;
	} result_t;

	// request handed from the front to the back
	typedef struct packed {
		logic               in_range;
		logic [INDEX_W-1:0] pixel_index;
		logic [DIST_W-1:0]  distance;
		logic [LBL_W-1:0]   label;
		logic [TAG_W-1:0]   tag;
	} queue_t;

	typedef struct packed {
		logic                  full;
		logic                  not_empty;
		logic [FIFO_CNT_W-1:0] count;
	} fifo_stat_t;

endpackage

FILE: rtl/sda_fifo.sv
`timescale 1ns / 1ps
// sda_fifo: small register FIFO with count and status.
// Depends on sda_pkg for depth and status type.

module sda_fifo #(
	parameter type ENTRY_T = sda_pkg::queue_t
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ENTRY_T              wdata,
	input  logic                pop,
	output ENTRY_T              rdata,
	output sda_pkg::fifo_stat_t stat
);

	ENTRY_T                          entry_q [sda_pkg::FIFO_DEPTH];
	logic [sda_pkg::FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [sda_pkg::FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [sda_pkg::FIFO_CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= wdata;
	end

	assign rdata          = entry_q[rd_ptr_q];
	assign stat.count     = count_q;
	assign stat.not_empty = (count_q != '0);
	assign stat.full      = (count_q == sda_pkg::FIFO_CNT_W'(sda_pkg::FIFO_DEPTH));

endmodule

FILE: rtl/sda_front.sv
`timescale 1ns / 1ps
// sda_front: five-stage distance and index pipeline feeding the request queue.
// Depends on sda_pkg.

module sda_front #(
	parameter int PIXEL_COUNT = sda_pkg::PIXEL_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sda_pkg::cfg_t       cfg,
	input  logic                item_valid,
	output logic                item_ready,
	input  sda_pkg::item_t      item,
	output logic                q_push,
	output sda_pkg::queue_t     q_data,
	input  sda_pkg::fifo_stat_t q_stat
);

	function automatic logic [27:0] sq_diff(input logic [13:0] a, input logic [13:0] b);
		logic [13:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return 28'(d) * 28'(d);
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	sda_pkg::item_t item_s1;

	logic [27:0] sqx_s2, sqy_s2, sqz_s2, sqc0_s2, sqc1_s2, sqc2_s2;
	logic [20:0] pyw_s2, zw_s2;
	logic [9:0]  px_s2;
	logic        ok_s2;
	logic [11:0] label_s2, label_s3, label_s4;
	logic [3:0]  tag_s2, tag_s3, tag_s4;

	logic [29:0] ds_s3, dc_s3, dc_s4;
	logic [31:0] zwh_s3, idx_s4;
	logic [21:0] pxy_s3;
	logic        ok_s3, ok_s4;
	logic [53:0] prod_s4;

	sda_pkg::queue_t q_s5;

	logic [9:0]  zi;
	logic [38:0] rnd;
	logic [40:0] dsum;

	assign adv        = !(v_s5 && q_stat.full);
	assign item_ready = adv;
	assign q_push     = v_s5 && !q_stat.full;
	assign q_data     = q_s5;

	assign zi   = cfg.three_d ? item_s1.pixel_z : 10'd0;
	assign rnd  = 39'((55'(prod_s4) + 55'(32768)) >> 16);
	assign dsum = 41'(rnd) + 41'(dc_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;

			sqx_s2  <= sq_diff(item_s1.center_x, {item_s1.pixel_x, 4'b0});
			sqy_s2  <= sq_diff(item_s1.center_y, {item_s1.pixel_y, 4'b0});
			sqz_s2  <= cfg.three_d ? sq_diff(item_s1.center_z, {item_s1.pixel_z, 4'b0}) : '0;
			sqc0_s2 <= sq_diff(item_s1.center_color[11:0], {item_s1.pixel_color[7:0], 4'b0});
			sqc1_s2 <= cfg.color_mode ?
				sq_diff(item_s1.center_color[23:12], {item_s1.pixel_color[15:8], 4'b0}) : '0;
			sqc2_s2 <= cfg.color_mode ?
				sq_diff(item_s1.center_color[35:24], {item_s1.pixel_color[23:16], 4'b0}) : '0;
			pyw_s2   <= 21'(item_s1.pixel_y) * 21'(cfg.image_width);
			zw_s2    <= 21'(zi) * 21'(cfg.image_width);
			px_s2    <= item_s1.pixel_x;
			ok_s2    <= ({1'b0, item_s1.pixel_x} < cfg.image_width) &&
				({1'b0, item_s1.pixel_y} < cfg.image_height);
			label_s2 <= item_s1.cell_label;
			tag_s2   <= item_s1.pass_tag;

			ds_s3    <= 30'(sqx_s2) + 30'(sqy_s2) + 30'(sqz_s2);
			dc_s3    <= 30'(sqc0_s2) + 30'(sqc1_s2) + 30'(sqc2_s2);
			zwh_s3   <= 32'(zw_s2) * 32'(cfg.image_height);
			pxy_s3   <= 22'(px_s2) + 22'(pyw_s2);
			ok_s3    <= ok_s2;
			label_s3 <= label_s2;
			tag_s3   <= tag_s2;

			prod_s4  <= 54'(ds_s3) * 54'(cfg.spatial_factor);
			idx_s4   <= 32'(pxy_s3) + zwh_s3;
			dc_s4    <= dc_s3;
			ok_s4    <= ok_s3;
			label_s4 <= label_s3;
			tag_s4   <= tag_s3;

			q_s5.in_range    <= ok_s4 && (idx_s4 < 32'(PIXEL_COUNT));
			q_s5.pixel_index <= idx_s4[sda_pkg::INDEX_W-1:0];
			q_s5.distance    <= dsum[40] ? '1 : dsum[sda_pkg::DIST_W-1:0];
			q_s5.label       <= label_s4;
			q_s5.tag         <= tag_s4;
		end
	end

endmodule

FILE: rtl/sda_back.sv
`timescale 1ns / 1ps
// sda_back: per-pixel minimum store with read-modify-write, forwarding and
// the clearing pass after reset. Depends on sda_pkg.

module sda_back #(
	parameter int PIXEL_COUNT = sda_pkg::PIXEL_COUNT_DEF,
	parameter int LABEL_BITS  = sda_pkg::LABEL_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sda_pkg::queue_t     q_head,
	input  sda_pkg::fifo_stat_t q_stat,
	output logic                q_pop,
	input  sda_pkg::fifo_stat_t res_stat,
	output logic                res_push,
	output sda_pkg::result_t    res_data
);

	localparam int AW = $clog2(PIXEL_COUNT);

	typedef struct packed {
		logic [sda_pkg::TAG_W-1:0]  tag;
		logic [LABEL_BITS-1:0]      label;
		logic [sda_pkg::DIST_W-1:0] distance;
	} entry_t;

	entry_t pixel_store_q [PIXEL_COUNT];

	logic            clr_q;
	logic [AW-1:0]   clr_addr_q;
	entry_t          rd_data_q;
	logic            fwd_v_q;
	logic [AW-1:0]   fwd_addr_q;
	entry_t          fwd_data_q;

	logic            b_v_s1;
	sda_pkg::queue_t b_item_s1;

	logic [sda_pkg::FIFO_CNT_W:0] pend;
	logic [AW-1:0]   rd_addr, b_addr, mem_wa;
	entry_t          cur, upd, after, mem_wd;
	logic            win, mem_we;

	assign pend  = {1'b0, res_stat.count} + (sda_pkg::FIFO_CNT_W + 1)'(b_v_s1);
	assign q_pop = q_stat.not_empty && !clr_q &&
		(pend < (sda_pkg::FIFO_CNT_W + 1)'(sda_pkg::FIFO_DEPTH));

	assign rd_addr = q_head.pixel_index[AW-1:0];
	assign b_addr  = b_item_s1.pixel_index[AW-1:0];

	always_comb begin
		cur = (fwd_v_q && fwd_addr_q == b_addr) ? fwd_data_q : rd_data_q;
		upd.tag      = b_item_s1.tag;
		upd.label    = LABEL_BITS'(b_item_s1.label);
		upd.distance = b_item_s1.distance;
		win   = b_item_s1.in_range &&
			((cur.tag != b_item_s1.tag) || (b_item_s1.distance < cur.distance));
		after = win ? upd : cur;
		mem_we = clr_q || (b_v_s1 && win);
		mem_wa = clr_q ? clr_addr_q : b_addr;
		mem_wd = clr_q ? '0 : upd;
	end

	assign res_push = b_v_s1;
	assign res_data.pixel_index   = b_item_s1.pixel_index;
	assign res_data.won           = win;
	assign res_data.best_label    = b_item_s1.in_range ? sda_pkg::LBL_W'(after.label) : '0;
	assign res_data.best_distance = b_item_s1.in_range ? after.distance : '0;

	always_ff @(posedge clk) begin
		if (mem_we)
			pixel_store_q[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= pixel_store_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			fwd_v_q    <= 1'b0;
			b_v_s1     <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(PIXEL_COUNT - 1))
					clr_q <= 1'b0;
			end
			fwd_v_q <= mem_we && !clr_q;
			b_v_s1  <= q_pop;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= mem_wa;
		fwd_data_q <= mem_wd;
		if (q_pop)
			b_item_s1 <= q_head;
	end

endmodule

FILE: rtl/slic_distance_assign_core.sv
`timescale 1ns / 1ps
// slic_distance_assign_core: top level of the SLIC pixel-to-center assignment step.
// Depends on sda_pkg, sda_front, sda_fifo and sda_back.
//
// Usage:
// - item channel (item_valid/item_ready/item): one pixel evaluated against one
//   cluster center per request. result channel (result_valid/result_ready/result):
//   one result per request, in request order.
// - cfg_we/cfg_index/cfg_data write the five config registers; write only while
//   no request is in flight.
// - Throughput: one request per cycle while nothing stalls. The front is a
//   five-stage distance and index pipeline; the back does one read-modify-write
//   of the pixel store per cycle, with the previous cycle's write forwarded.
// - Path: an accepted request passes the five front stages, the request queue,
//   the back's issue register and the result FIFO before result_valid rises.
// - Reset: config returns to its defaults, then the back clears the label, tag
//   and distance store, one entry per cycle, over PIXEL_COUNT entries (65536 by default).
//   Requests are taken meanwhile until the pipeline and queue fill.
// - Receiver stall: a 4-entry result FIFO absorbs results; the back issues only
//   when room is reserved there, and the front stalls when the request queue is
//   full and its last stage holds a request, deasserting item_ready.

module slic_distance_assign_core #(
	parameter int PIXEL_COUNT = sda_pkg::PIXEL_COUNT_DEF,
	parameter int LABEL_BITS  = sda_pkg::LABEL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sda_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sda_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  sda_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output sda_pkg::result_t                result
);

	sda_pkg::cfg_t       cfg_q;
	logic                q_push, q_pop, res_push, res_pop;
	sda_pkg::queue_t     q_wdata, q_head;
	sda_pkg::fifo_stat_t q_stat, res_stat;
	sda_pkg::result_t    res_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spatial_factor <= 24'd65536;
			cfg_q.three_d        <= 1'b0;
			cfg_q.color_mode     <= 1'b1;
			cfg_q.image_width    <= 11'd256;
			cfg_q.image_height   <= 11'd256;
		end else if (cfg_we) begin
			unique case (sda_pkg::cfg_reg_t'(cfg_index))
				sda_pkg::CFG_SPATIAL_FACTOR: cfg_q.spatial_factor <= cfg_data;
				sda_pkg::CFG_THREE_D:        cfg_q.three_d        <= cfg_data[0];
				sda_pkg::CFG_COLOR_MODE:     cfg_q.color_mode     <= cfg_data[0];
				sda_pkg::CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_data[10:0];
				sda_pkg::CFG_IMAGE_HEIGHT:   cfg_q.image_height   <= cfg_data[10:0];
				default: begin
				end
			endcase
		end
	end

	sda_front #(
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_push     (q_push),
		.q_data     (q_wdata),
		.q_stat     (q_stat)
	);

	sda_fifo #(
		.ENTRY_T(sda_pkg::queue_t)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_head),
		.stat   (q_stat)
	);

	sda_back #(
		.PIXEL_COUNT(PIXEL_COUNT),
		.LABEL_BITS (LABEL_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_head   (q_head),
		.q_stat   (q_stat),
		.q_pop    (q_pop),
		.res_stat (res_stat),
		.res_push (res_push),
		.res_data (res_wdata)
	);

	sda_fifo #(
		.ENTRY_T(sda_pkg::result_t)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (res_pop),
		.rdata  (result),
		.stat   (res_stat)
	);

	assign result_valid = res_stat.not_empty;
	assign res_pop      = result_valid && result_ready;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (!res_stat.full || res_pop))
		else $error("result fifo overflow");

	a_q_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("request queue overflow");

	a_q_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_stat.not_empty)
		else $error("request queue underflow");

	a_res_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> res_push)
		else $error("issued request did not produce a result");

endmodule

FILE: test/tb_slic_distance_assign_core.sv
`timescale 1ns / 1ps
// tb_slic_distance_assign_core: self-checking bench for the SLIC pixel-to-center
// assignment core. Holds a scoreboard class that tracks the per-pixel minimum,
// label and tag stores. Depends on sda_pkg and slic_distance_assign_core.

module tb_slic_distance_assign_core;

	localparam int STORE_AW = $clog2(sda_pkg::PIXEL_COUNT_DEF);

	class pixel_assign_sb;
		sda_pkg::cfg_t                 cfg;
		bit [sda_pkg::DIST_W-1:0]      min_dist [sda_pkg::PIXEL_COUNT_DEF];
		bit [sda_pkg::LBL_W-1:0]       label_of [sda_pkg::PIXEL_COUNT_DEF];
		bit [sda_pkg::TAG_W-1:0]       tag_of [sda_pkg::PIXEL_COUNT_DEF];
		bit                            dist_known [sda_pkg::PIXEL_COUNT_DEF];
		sda_pkg::result_t              expected_assign [$];
		int unsigned                   errors, checked, wins, holds, outside;

		function new();
			cfg.spatial_factor = 24'd65536;
			cfg.three_d = 1'b0;
			cfg.color_mode = 1'b1;
			cfg.image_width = 11'd256;
			cfg.image_height = 11'd256;
		endfunction

		function bit locate(sda_pkg::item_t it, output bit [63:0] idx);
			bit [63:0] w, h, z;
			w = 64'(cfg.image_width);
			h = 64'(cfg.image_height);
			z = cfg.three_d ? 64'(it.pixel_z) : 64'd0;
			idx = 64'(it.pixel_x) + 64'(it.pixel_y) * w + z * w * h;
			return 64'(it.pixel_x) < w && 64'(it.pixel_y) < h &&
				idx < 64'(sda_pkg::PIXEL_COUNT_DEF);
		endfunction

		function bit [63:0] sq_gap(bit [63:0] a, bit [63:0] b);
			bit [63:0] d;
			d = (a >= b) ? a - b : b - a;
			return d * d;
		endfunction

		function void predict_assignment(sda_pkg::item_t it);
			bit [63:0] idx, span, tone, total;
			bit [STORE_AW-1:0] slot;
			sda_pkg::result_t r;
			r = '0;
			if (locate(it, idx)) begin
				slot = idx[STORE_AW-1:0];
				span = sq_gap(64'(it.center_x), 64'({it.pixel_x, 4'd0}))
					+ sq_gap(64'(it.center_y), 64'({it.pixel_y, 4'd0}));
				if (cfg.three_d)
					span += sq_gap(64'(it.center_z), 64'({it.pixel_z, 4'd0}));
				tone = sq_gap(64'(it.center_color[11:0]), 64'({it.pixel_color[7:0], 4'd0}));
				if (cfg.color_mode) begin
					tone += sq_gap(64'(it.center_color[23:12]),
						64'({it.pixel_color[15:8], 4'd0}));
					tone += sq_gap(64'(it.center_color[35:24]),
						64'({it.pixel_color[23:16], 4'd0}));
				end
				total = tone + ((span * 64'(cfg.spatial_factor) + 64'd32768) >> 16);
				if (total > 64'({sda_pkg::DIST_W{1'b1}}))
					total = 64'({sda_pkg::DIST_W{1'b1}});
				if (tag_of[slot] != it.pass_tag || total < 64'(min_dist[slot])) begin
					r.won = 1'b1;
					min_dist[slot] = total[sda_pkg::DIST_W-1:0];
					label_of[slot] = it.cell_label;
					tag_of[slot] = it.pass_tag;
					dist_known[slot] = 1'b1;
					wins++;
				end else if (total == 64'(min_dist[slot])) begin
					holds++;
				end
				r.best_label = label_of[slot];
				r.best_distance = min_dist[slot];
			end else begin
				outside++;
			end
			r.pixel_index = idx[sda_pkg::INDEX_W-1:0];
			expected_assign.push_back(r);
		endfunction

		function void check_assignment(sda_pkg::result_t got);
			sda_pkg::result_t want;
			if (expected_assign.size() == 0) begin
				$error("result with none expected: pixel_index %0d", got.pixel_index);
				errors++;
				return;
			end
			want = expected_assign.pop_front();
			checked++;
			if (got.pixel_index !== want.pixel_index) begin
				$error("pixel_index: expected %0d, got %0d", want.pixel_index, got.pixel_index);
				errors++;
			end
			if (got.won !== want.won) begin
				$error("won: expected %0d, got %0d (pixel %0d)", want.won, got.won,
					want.pixel_index);
				errors++;
			end
			if (got.best_label !== want.best_label) begin
				$error("best_label: expected %0d, got %0d (pixel %0d)", want.best_label,
					got.best_label, want.pixel_index);
				errors++;
			end
			if (got.best_distance !== want.best_distance) begin
				$error("best_distance: expected %0d, got %0d (pixel %0d)",
					want.best_distance, got.best_distance, want.pixel_index);
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [sda_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sda_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           item_valid = 1'b0;
	logic                           item_ready;
	sda_pkg::item_t                 req_item = '0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	sda_pkg::result_t               result;

	pixel_assign_sb sb;
	sda_pkg::item_t pixel_pool [8];
	int unsigned    requests_sent = 0;
	bit             item_idling = 1'b0;
	bit             result_idling = 1'b0;

	slic_distance_assign_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(req_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= !(result_idling && $urandom_range(99) < 7);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				sb.predict_assignment(req_item);
			if (result_valid && result_ready)
				sb.check_assignment(result);
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input sda_pkg::item_t it);
		bit [63:0] idx;
		// tag 0 may only hit an entry whose minimum has been written
		if (it.pass_tag == '0 && sb.locate(it, idx) && !sb.dist_known[idx[STORE_AW-1:0]])
			it.pass_tag = 4'd1;
		while (item_idling && $urandom_range(99) < 7) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		req_item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (sb.expected_assign.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic apply_config(input sda_pkg::cfg_t c);
		cfg_we <= 1'b1;
		cfg_index <= sda_pkg::CFG_SPATIAL_FACTOR;
		cfg_data <= c.spatial_factor;
		@(negedge clk);
		cfg_index <= sda_pkg::CFG_THREE_D;
		cfg_data <= {23'd0, c.three_d};
		@(negedge clk);
		cfg_index <= sda_pkg::CFG_COLOR_MODE;
		cfg_data <= {23'd0, c.color_mode};
		@(negedge clk);
		cfg_index <= sda_pkg::CFG_IMAGE_WIDTH;
		cfg_data <= {13'd0, c.image_width};
		@(negedge clk);
		cfg_index <= sda_pkg::CFG_IMAGE_HEIGHT;
		cfg_data <= {13'd0, c.image_height};
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.cfg = c;
	endtask

	function automatic int jitter(int base, int reach, int top);
		int v;
		v = base + int'($urandom_range(2 * reach)) - reach;
		if (v < 0)
			v = 0;
		if (v > top)
			v = top;
		return v;
	endfunction

	// in-range pixel for the current image size and mode
	function automatic sda_pkg::item_t pool_pixel();
		sda_pkg::item_t p;
		int unsigned w, h, area, row_cap, z_cap;
		w = 32'(sb.cfg.image_width);
		h = 32'(sb.cfg.image_height);
		area = w * h;
		row_cap = (sda_pkg::PIXEL_COUNT_DEF / w < h) ? sda_pkg::PIXEL_COUNT_DEF / w : h;
		p = '0;
		p.pixel_x = 10'($urandom_range(w - 1));
		p.pixel_y = 10'($urandom_range(row_cap - 1));
		p.pixel_color = 24'($urandom);
		if (!sb.cfg.three_d) begin
			p.pixel_z = 10'($urandom);
		end else if (area <= sda_pkg::PIXEL_COUNT_DEF) begin
			z_cap = sda_pkg::PIXEL_COUNT_DEF / area - 1;
			if (z_cap > 1023)
				z_cap = 1023;
			p.pixel_z = 10'($urandom_range(z_cap));
		end
		return p;
	endfunction

	function automatic sda_pkg::item_t aim_center(sda_pkg::item_t it);
		int reach;
		case ($urandom_range(3))
			0: reach = 0;
			1: reach = 8;
			2: reach = 300;
			default: reach = 20000;
		endcase
		it.center_x = 14'(jitter(it.pixel_x * 16, reach, 16383));
		it.center_y = 14'(jitter(it.pixel_y * 16, reach, 16383));
		it.center_z = 14'(jitter(it.pixel_z * 16, reach, 16383));
		it.center_color[11:0] = 12'(jitter(it.pixel_color[7:0] * 16, reach, 4095));
		it.center_color[23:12] = 12'(jitter(it.pixel_color[15:8] * 16, reach, 4095));
		it.center_color[35:24] = 12'(jitter(it.pixel_color[23:16] * 16, reach, 4095));
		return it;
	endfunction

	// one pixel against a few candidate centers in the same pass, or one random item
	task automatic visit_pixel(input logic [sda_pkg::TAG_W-1:0] tag);
		sda_pkg::item_t it;
		logic [159:0]   noise;
		int unsigned    evals;
		if ($urandom_range(9) == 0) begin
			noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
			send_request(noise[$bits(sda_pkg::item_t)-1:0]);
			return;
		end
		it = pixel_pool[3'($urandom_range(7))];
		it.pass_tag = ($urandom_range(11) == 0) ? 4'd0 : tag;
		evals = $urandom_range(6, 1);
		for (int k = 0; k < evals; k++) begin
			// reusing the last center gives an equal distance
			if (k == 0 || $urandom_range(3) != 0)
				it = aim_center(it);
			it.cell_label = 12'($urandom_range(4095, 1));
			send_request(it);
		end
	endtask

	task automatic run_phase(input sda_pkg::cfg_t c, input int unsigned count, input bit idle);
		logic [sda_pkg::TAG_W-1:0] tag;
		int unsigned               stop_at;
		item_valid <= 1'b0;
		wait_idle();
		apply_config(c);
		item_idling = idle;
		result_idling = idle;
		foreach (pixel_pool[i])
			pixel_pool[i] = pool_pixel();
		tag = 4'($urandom_range(15, 1));
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			visit_pixel(tag);
			if ($urandom_range(7) == 0)
				tag = (tag == 4'd15) ? 4'd1 : tag + 4'd1;
		end
	endtask

	initial begin
		sda_pkg::item_t d;
		sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		item_idling = 1'b1;
		result_idling = 1'b1;

		d = '0;
		d.cell_label = 12'd1;
		d.pass_tag = 4'd1;
		send_request(d);
		d.cell_label = 12'd4095;
		send_request(d);
		d.center_x = 14'h3fff;
		d.cell_label = 12'd2;
		send_request(d);
		d.pass_tag = 4'd2;
		d.cell_label = 12'd3;
		send_request(d);
		d.center_x = '0;
		d.pass_tag = 4'd0;
		d.cell_label = 12'd5;
		send_request(d);
		d.cell_label = 12'd6;
		send_request(d);
		d = '1;
		d.pixel_x = 10'd255;
		d.pixel_y = 10'd255;
		send_request(d);
		d.pixel_x = 10'd256;
		send_request(d);
		d.pixel_x = 10'd0;
		d.pixel_y = 10'd256;
		send_request(d);
		d.pixel_x = 10'd1023;
		d.pixel_y = 10'd1023;
		send_request(d);
		d = '0;
		d.pixel_x = 10'd17;
		d.pixel_y = 10'd3;
		d.pixel_z = 10'd1023;
		d.pixel_color = 24'h123456;
		d.center_x = 14'd272;
		d.center_y = 14'd48;
		d.center_z = 14'h2a5a;
		d.center_color = {8'h12, 4'h0, 8'h34, 4'h0, 8'h56, 4'h0};
		d.cell_label = 12'd7;
		d.pass_tag = 4'd4;
		send_request(d);
		d.center_x = 14'd280;
		d.cell_label = 12'd8;
		send_request(d);
		d.center_x = 14'd264;
		d.cell_label = 12'd9;
		send_request(d);

		run_phase('{spatial_factor: 24'd0, three_d: 1'b1, color_mode: 1'b0,
			image_width: 11'd1, image_height: 11'd1}, 70, 1'b1);
		run_phase('{spatial_factor: 24'hffffff, three_d: 1'b0, color_mode: 1'b1,
			image_width: 11'd1024, image_height: 11'd64}, 80, 1'b0);
		run_phase('{spatial_factor: 24'd65536, three_d: 1'b1, color_mode: 1'b1,
			image_width: 11'd1024, image_height: 11'd1024}, 70, 1'b1);
		run_phase('{spatial_factor: 24'($urandom), three_d: 1'b1, color_mode: 1'b0,
			image_width: 11'd16, image_height: 11'd8}, 80, 1'b1);
		run_phase('{spatial_factor: 24'($urandom_range(65535)), three_d: 1'b0,
			color_mode: 1'b1, image_width: 11'd37, image_height: 11'd5}, 90, 1'b1);

		item_valid <= 1'b0;
		wait_idle();
		repeat (20) @(negedge clk);
		if (sb.expected_assign.size() != 0) begin
			$error("%0d results never arrived", sb.expected_assign.size());
			sb.errors++;
		end
		$display("%0d pixel evaluations checked over six register settings", sb.checked);
		$display("  %0d wins, %0d equal-distance holds, %0d outside the image",
			sb.wins, sb.holds, sb.outside);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/sda_pkg.sv
rtl/sda_fifo.sv
rtl/sda_front.sv
rtl/sda_back.sv
rtl/slic_distance_assign_core.sv
test/tb_slic_distance_assign_core.sv
